// ----- sv/scrolling_2d_ring_grid_core_macros.svh -----
// ----------------------------------------------------------------------------
// Scrolling ring grid assertion macros
// Concurrent check helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_2D_RING_GRID_CORE_MACROS_SVH
`define SCROLLING_2D_RING_GRID_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define S2RG_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s2rg: same-cycle check failed");

// next-cycle implication
`define S2RG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s2rg: next-cycle check failed");

`else

`define S2RG_ASSERT_IMPL(name, clk, rst, ante, cons)
`define S2RG_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- sv/s2rg_pkg.sv -----
// ----------------------------------------------------------------------------
// s2rg_pkg
// Shared types and constants of the scrolling ring grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2rg_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_CELL_WIDTH = 64;

  localparam int IDX_W      = 7;
  localparam int SHIFT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [IDX_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SHIFT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_USED = 2'd0,
    CFG_COLS_USED = 2'd1,
    CFG_DEFAULT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic rem_start;
    logic rem_sel_delta;
    logic load_mod;
    logic shift_setup;
    logic rfill_wr;
    logic cfill_wr;
    logic rsp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic dirty;
    logic rem_busy;
    logic row_move;
    logic col_move;
    logic rfill_last;
    logic cfill_last;
    logic rsp_free;
  } dp_status_t;

endpackage

// ----- sv/s2rg_if.sv -----
// ----------------------------------------------------------------------------
// s2rg interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface s2rg_in_if #(
  parameter int CELL_WIDTH = s2rg_pkg::DEF_CELL_WIDTH
);
  logic                                valid;
  logic                                ready;
  s2rg_pkg::op_t                       op;
  logic [s2rg_pkg::IDX_W-1:0]          row_index;
  logic [s2rg_pkg::IDX_W-1:0]          col_index;
  logic [CELL_WIDTH-1:0]               write_value;
  logic signed [s2rg_pkg::SHIFT_W-1:0] row_shift;
  logic signed [s2rg_pkg::SHIFT_W-1:0] col_shift;

  modport source (output valid, op, row_index, col_index, write_value, row_shift,
                  col_shift, input ready);
  modport sink (input valid, op, row_index, col_index, write_value, row_shift,
                col_shift, output ready);
endinterface

interface s2rg_out_if #(
  parameter int CELL_WIDTH = s2rg_pkg::DEF_CELL_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [CELL_WIDTH-1:0] read_value;
  logic                  status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

interface s2rg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [s2rg_pkg::CFG_IDX_W-1:0]  index;
  logic [s2rg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/s2rg_ram.sv -----
// ----------------------------------------------------------------------------
// s2rg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2rg_ram #(
  parameter int WIDTH = s2rg_pkg::DEF_CELL_WIDTH,
  parameter int DEPTH = s2rg_pkg::DEF_MAX_ROWS * s2rg_pkg::DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/s2rg_rem.sv -----
// ----------------------------------------------------------------------------
// s2rg_rem
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2rg_rem #(
  parameter int DIV_W = s2rg_pkg::SHIFT_W,
  parameter int N_W   = s2rg_pkg::IDX_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [N_W-1:0]   divisor,
  output logic [N_W-1:0]   remainder,
  output logic             busy
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] shreg;
  logic [N_W-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [N_W:0]     trial;
  logic [N_W:0]     dvs;

  assign trial     = {rem, shreg[DIV_W-1]};
  assign dvs       = {1'b0, divisor};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // rem stays below divisor, so trial is below twice the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= (trial >= dvs) ? N_W'(trial - dvs) : N_W'(trial);
    end
  end

endmodule

// ----- sv/s2rg_dp.sv -----
// ----------------------------------------------------------------------------
// s2rg_dp
// Datapath: config registers, origins, address mapping, refill walker,
// remainder lanes, cell RAM and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2rg_dp #(
  parameter int MAX_ROWS   = s2rg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = s2rg_pkg::DEF_MAX_COLS,
  parameter int CELL_WIDTH = s2rg_pkg::DEF_CELL_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  s2rg_pkg::ctrl_cmd_t                 cmd,
  output s2rg_pkg::dp_status_t                stat,
  input  s2rg_pkg::op_t                       req_op,
  input  logic [s2rg_pkg::IDX_W-1:0]          req_row_index,
  input  logic [s2rg_pkg::IDX_W-1:0]          req_col_index,
  input  logic [CELL_WIDTH-1:0]               req_write_value,
  input  logic signed [s2rg_pkg::SHIFT_W-1:0] req_row_shift,
  input  logic signed [s2rg_pkg::SHIFT_W-1:0] req_col_shift,
  input  logic                                cfg_valid,
  input  logic [s2rg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [s2rg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic [CELL_WIDTH-1:0]               rsp_read_value,
  output logic                                rsp_status
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = (RW > CW) ? RW : CW;
  localparam int DW    = (OW > s2rg_pkg::SHIFT_W) ? OW : s2rg_pkg::SHIFT_W;
  localparam int SW    = s2rg_pkg::SHIFT_W;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic [SW-1:0] magnitude(input logic signed [SW-1:0] d);
    magnitude = d[SW-1] ? SW'(-d) : SW'(d);
  endfunction

  // configuration
  logic [s2rg_pkg::IDX_W-1:0] rows_used;
  logic [s2rg_pkg::IDX_W-1:0] cols_used;
  logic [CELL_WIDTH-1:0]      default_value;
  logic                       dirty;

  // dirty drops when a reduction pass starts; a size write during the pass
  // raises it again so the pass is repeated with the final sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used     <= s2rg_pkg::SIZE_RESET;
      cols_used     <= s2rg_pkg::SIZE_RESET;
      default_value <= '0;
      dirty         <= 1'b0;
    end else begin
      if (cmd.rem_start) begin
        dirty <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          s2rg_pkg::CFG_ROWS_USED: begin
            rows_used <= cfg_data[s2rg_pkg::IDX_W-1:0];
            dirty     <= 1'b1;
          end
          s2rg_pkg::CFG_COLS_USED: begin
            cols_used <= cfg_data[s2rg_pkg::IDX_W-1:0];
            dirty     <= 1'b1;
          end
          s2rg_pkg::CFG_DEFAULT: begin
            default_value <= cfg_data[CELL_WIDTH-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // sizes in use: zero counts as one, saturate at the built size
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;

  always_comb begin
    if (rows_used == '0) begin
      nr = NRW'(1);
    end else if (32'(rows_used) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_used);
    end
    if (cols_used == '0) begin
      nc = NCW'(1);
    end else if (32'(cols_used) > MAX_COLS) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_used);
    end
  end

  // raw origins and their remainders modulo the sizes in use
  logic [RW-1:0] row_org;
  logic [CW-1:0] col_org;
  logic [RW-1:0] rmod;
  logic [CW-1:0] cmod;

  // remainder lanes
  logic [DW-1:0]  row_div_in;
  logic [DW-1:0]  col_div_in;
  logic [NRW-1:0] row_rem;
  logic [NCW-1:0] col_rem;
  logic           row_busy;
  logic           col_busy;

  assign row_div_in = cmd.rem_sel_delta ? DW'(magnitude(req_row_shift)) : DW'(row_org);
  assign col_div_in = cmd.rem_sel_delta ? DW'(magnitude(req_col_shift)) : DW'(col_org);

  s2rg_rem #(.DIV_W(DW), .N_W(NRW)) u_row_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.rem_start),
    .dividend  (row_div_in),
    .divisor   (nr),
    .remainder (row_rem),
    .busy      (row_busy)
  );

  s2rg_rem #(.DIV_W(DW), .N_W(NCW)) u_col_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.rem_start),
    .dividend  (col_div_in),
    .divisor   (nc),
    .remainder (col_rem),
    .busy      (col_busy)
  );

  // logical to physical mapping for the item on the request port
  logic           in_range;
  logic [NRW:0]   rsum;
  logic [NCW:0]   csum;
  logic [RW-1:0]  pr;
  logic [CW-1:0]  pc;
  logic [AW-1:0]  acc_addr;

  always_comb begin
    in_range = (32'(req_row_index) < 32'(nr)) && (32'(req_col_index) < 32'(nc));
    rsum     = (NRW+1)'(req_row_index) + (NRW+1)'(rmod);
    csum     = (NCW+1)'(req_col_index) + (NCW+1)'(cmod);
    pr       = (rsum >= {1'b0, nr}) ? RW'(rsum - {1'b0, nr}) : RW'(rsum);
    pc       = (csum >= {1'b0, nc}) ? CW'(csum - {1'b0, nc}) : CW'(csum);
    acc_addr = cell_addr(pr, pc);
  end

  // captured item
  logic                 res_ram;
  logic [CELL_WIDTH-1:0] res_val;
  logic                 res_status;
  logic signed [SW-1:0] dr_q;
  logic signed [SW-1:0] dc_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_ram    <= (req_op == s2rg_pkg::OP_READ) && in_range;
      res_val    <= ((req_op == s2rg_pkg::OP_READ) && !in_range) ? default_value : '0;
      res_status <= ((req_op == s2rg_pkg::OP_READ) || (req_op == s2rg_pkg::OP_WRITE))
                    && !in_range;
      dr_q       <= req_row_shift;
      dc_q       <= req_col_shift;
    end
  end

  // new origins and refill ranges once the delta remainders are in
  logic [SW-1:0]  rmag;
  logic [SW-1:0]  cmag;
  logic           row_full;
  logic           col_full;
  logic [NRW:0]   r_up;
  logic [NRW:0]   r_dn;
  logic [NCW:0]   c_up;
  logic [NCW:0]   c_dn;
  logic [RW-1:0]  row_neu;
  logic [CW-1:0]  col_neu;
  logic [RW-1:0]  row_start;
  logic [CW-1:0]  col_start;
  logic [NRW-1:0] row_count;
  logic [NCW-1:0] col_count;

  always_comb begin
    rmag     = magnitude(dr_q);
    cmag     = magnitude(dc_q);
    row_full = 32'(rmag) >= 32'(nr);
    col_full = 32'(cmag) >= 32'(nc);

    r_up = (NRW+1)'(rmod) + (NRW+1)'(row_rem);
    if (r_up >= {1'b0, nr}) begin
      r_up = r_up - {1'b0, nr};
    end
    r_dn = (NRW+1)'(rmod) - (NRW+1)'(row_rem);
    if ((NRW+1)'(rmod) < (NRW+1)'(row_rem)) begin
      r_dn = r_dn + {1'b0, nr};
    end

    c_up = (NCW+1)'(cmod) + (NCW+1)'(col_rem);
    if (c_up >= {1'b0, nc}) begin
      c_up = c_up - {1'b0, nc};
    end
    c_dn = (NCW+1)'(cmod) - (NCW+1)'(col_rem);
    if ((NCW+1)'(cmod) < (NCW+1)'(col_rem)) begin
      c_dn = c_dn + {1'b0, nc};
    end

    row_neu   = dr_q[SW-1] ? RW'(r_dn) : RW'(r_up);
    col_neu   = dc_q[SW-1] ? CW'(c_dn) : CW'(c_up);
    // moving forward exposes rows from the old origin, backward from the new one
    row_start = row_full ? '0 : (dr_q[SW-1] ? row_neu : rmod);
    col_start = col_full ? '0 : (dc_q[SW-1] ? col_neu : cmod);
    row_count = row_full ? nr : NRW'(rmag);
    col_count = col_full ? nc : NCW'(cmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_org <= '0;
      col_org <= '0;
      rmod    <= '0;
      cmod    <= '0;
    end else if (cmd.load_mod) begin
      rmod <= RW'(row_rem);
      cmod <= CW'(col_rem);
    end else if (cmd.shift_setup) begin
      if (dr_q != '0) begin
        row_org <= row_neu;
        rmod    <= row_neu;
      end
      if (dc_q != '0) begin
        col_org <= col_neu;
        cmod    <= col_neu;
      end
    end
  end

  // refill walker: outer pointer per axis, shared inner counter
  logic [RW-1:0]  rptr;
  logic [CW-1:0]  cptr;
  logic [NRW-1:0] rcnt;
  logic [NCW-1:0] ccnt;
  logic [OW-1:0]  inner;
  logic           inner_col_end;
  logic           inner_row_end;

  assign inner_col_end = 32'(inner) == (32'(nc) - 32'd1);
  assign inner_row_end = 32'(inner) == (32'(nr) - 32'd1);

  always_ff @(posedge clk) begin
    if (cmd.shift_setup) begin
      rptr  <= row_start;
      cptr  <= col_start;
      rcnt  <= row_count;
      ccnt  <= col_count;
      inner <= '0;
    end else if (cmd.rfill_wr) begin
      if (inner_col_end) begin
        inner <= '0;
        rptr  <= (32'(rptr) == (32'(nr) - 32'd1)) ? '0 : rptr + RW'(1);
        rcnt  <= rcnt - NRW'(1);
      end else begin
        inner <= inner + OW'(1);
      end
    end else if (cmd.cfill_wr) begin
      if (inner_row_end) begin
        inner <= '0;
        cptr  <= (32'(cptr) == (32'(nc) - 32'd1)) ? '0 : cptr + CW'(1);
        ccnt  <= ccnt - NCW'(1);
      end else begin
        inner <= inner + OW'(1);
      end
    end
  end

  // post-reset clearing sweep
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // cell store
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CELL_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [CELL_WIDTH-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.accept && (req_op == s2rg_pkg::OP_WRITE) && in_range) begin
      ram_we    = 1'b1;
      ram_waddr = acc_addr;
      ram_wdata = req_write_value;
    end else if (cmd.rfill_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(rptr, CW'(inner));
      ram_wdata = default_value;
    end else if (cmd.cfill_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(RW'(inner), cptr);
      ram_wdata = default_value;
    end
    ram_re = cmd.accept && (req_op == s2rg_pkg::OP_READ) && in_range;
  end

  s2rg_ram #(.WIDTH(CELL_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (acc_addr),
    .rdata (ram_rdata)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp_read_value <= res_ram ? ram_rdata : res_val;
      rsp_status     <= res_status;
    end
  end

  always_comb begin
    stat            = '0;
    stat.clear_last = clr_addr == AW'(DEPTH - 1);
    stat.dirty      = dirty;
    stat.rem_busy   = row_busy | col_busy;
    stat.row_move   = dr_q != '0;
    stat.col_move   = dc_q != '0;
    stat.rfill_last = inner_col_end && (rcnt == NRW'(1));
    stat.cfill_last = inner_row_end && (ccnt == NCW'(1));
    stat.rsp_free   = !rsp_valid || rsp_ready;
  end

endmodule

// ----- sv/s2rg_ctrl.sv -----
// ----------------------------------------------------------------------------
// s2rg_ctrl
// Controller FSM: clearing sweep, origin reduction, access, shift refill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scrolling_2d_ring_grid_core_macros.svh"

module s2rg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  s2rg_pkg::op_t        req_op,
  input  s2rg_pkg::dp_status_t stat,
  output logic                 req_ready,
  output s2rg_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_SHDIV = 7'b0001000,
    ST_RFILL = 7'b0010000,
    ST_CFILL = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == ST_IDLE) && !stat.dirty;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // a size change invalidates the cached origin remainders
        if (stat.dirty) begin
          cmd.rem_start = 1'b1;
          state_next    = ST_MOD;
        end else if (req_valid) begin
          cmd.accept = 1'b1;
          if (req_op == s2rg_pkg::OP_SHIFT) begin
            cmd.rem_start     = 1'b1;
            cmd.rem_sel_delta = 1'b1;
            state_next        = ST_SHDIV;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_MOD: begin
        if (!stat.rem_busy) begin
          cmd.load_mod = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SHDIV: begin
        if (!stat.rem_busy) begin
          cmd.shift_setup = 1'b1;
          if (stat.row_move) begin
            state_next = ST_RFILL;
          end else if (stat.col_move) begin
            state_next = ST_CFILL;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_RFILL: begin
        cmd.rfill_wr = 1'b1;
        if (stat.rfill_last) begin
          state_next = stat.col_move ? ST_CFILL : ST_RESP;
        end
      end
      ST_CFILL: begin
        cmd.cfill_wr = 1'b1;
        if (stat.cfill_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat.rsp_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `S2RG_ASSERT_NEXT(a_access_to_resp, clk, rst, cmd.accept && (req_op != s2rg_pkg::OP_SHIFT), state == ST_RESP)
  `S2RG_ASSERT_NEXT(a_rem_runs, clk, rst, cmd.rem_start, stat.rem_busy)
  `S2RG_ASSERT_IMPL(a_fill_after_rem, clk, rst, (state == ST_RFILL) || (state == ST_CFILL), !stat.rem_busy)

endmodule

// ----- sv/scrolling_2d_ring_grid_core.sv -----
// ----------------------------------------------------------------------------
// scrolling_2d_ring_grid_core
// Toroidal cell store with wrapping row/column origins and scroll refill.
// ----------------------------------------------------------------------------
// After reset the core sweeps the cell RAM to zero, one cell per cycle,
// with req.ready low; configuration writes are taken at any time. For a
// read, write or no-op the address is mapped and the RAM accessed in the
// accept cycle, and the result enters the response register once that
// register is free. A shift runs the deltas through the bit-serial
// remainder lanes, W = max(8, log2 of the larger built dimension) bits
// wide, then writes the fill value into the refilled cells one per cycle;
// the refilled cells are rows_moved*cols_used + cols_moved*rows_used (a
// move of the full size or more counts the whole axis). A rows_used or
// cols_used write makes the core reduce the origins to the new sizes
// before it takes the next item, with req.ready low, and a further size
// write during that pass makes it run again. A finished result waits in
// the response register without blocking the core's return to idle.
`timescale 1ns / 1ps

module scrolling_2d_ring_grid_core #(
  parameter int MAX_ROWS   = s2rg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = s2rg_pkg::DEF_MAX_COLS,
  parameter int CELL_WIDTH = s2rg_pkg::DEF_CELL_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  s2rg_in_if.sink     req,
  s2rg_out_if.source  rsp,
  s2rg_cfg_if.sink    cfg
);

  s2rg_pkg::ctrl_cmd_t  cmd;
  s2rg_pkg::dp_status_t stat;

  assign cfg.ready = 1'b1;

  s2rg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .stat      (stat),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  s2rg_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_op          (req.op),
    .req_row_index   (req.row_index),
    .req_col_index   (req.col_index),
    .req_write_value (req.write_value),
    .req_row_shift   (req.row_shift),
    .req_col_shift   (req.col_shift),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_read_value  (rsp.read_value),
    .rsp_status      (rsp.status)
  );

endmodule

// ----- dv/s2rg_grid_checker.sv -----
// ----------------------------------------------------------------------------
// s2rg_grid_checker
// Watches the request, response and register channels of the ring grid,
// keeps its own copy of the cell store, origins and registers, predicts one
// result per accepted request and compares every response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2rg_grid_checker
  import s2rg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  s2rg_in_if   req,
  s2rg_out_if  rsp,
  s2rg_cfg_if  cfg,
  output int   pending,
  output int   errors,
  output int   checked
);

  localparam int ROWS = DEF_MAX_ROWS;
  localparam int COLS = DEF_MAX_COLS;
  localparam int CW   = DEF_CELL_WIDTH;
  localparam int PRINT_CAP = 100;

  typedef struct {
    logic [CW-1:0] value;
    logic          status;
  } cell_result_t;

  logic [CW-1:0]    cells [ROWS*COLS];
  int               row_org;
  int               col_org;
  logic [IDX_W-1:0] rows_reg;
  logic [IDX_W-1:0] cols_reg;
  logic [CW-1:0]    fill_value;
  cell_result_t     result_q [$];
  int               fail_count = 0;
  int               result_count = 0;

  assign errors  = fail_count;
  assign checked = result_count;

  function automatic int used_size(logic [IDX_W-1:0] r, int built);
    if (r == '0) return 1;
    if (int'(r) > built) return built;
    return int'(r);
  endfunction

  function automatic int wrap_origin(int origin, int delta, int n);
    int s;
    s = (origin % n) + (delta % n);
    s = s % n;
    if (s < 0) s += n;
    return s;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    // keep the log bounded when the design is badly off
    if (fail_count < PRINT_CAP)
      $display("ERROR t=%0t result %0d: %s got %h expected %h",
               $realtime, result_count, what, got, want);
    fail_count++;
  endtask

  // move one origin and refill the lines that come into view
  task automatic scroll_axis(input bit col_axis, input int d, input int nr, input int nc);
    int n, old_o, new_o, mag, first, span, line;
    n     = col_axis ? nc : nr;
    old_o = (col_axis ? col_org : row_org) % n;
    new_o = wrap_origin(old_o, d, n);
    mag   = (d < 0) ? -d : d;
    if (col_axis) col_org = new_o;
    else row_org = new_o;
    first = (mag >= n) ? 0 : ((d > 0) ? old_o : new_o);
    span  = (mag >= n) ? n : mag;
    for (int k = 0; k < span; k++) begin
      line = (first + k) % n;
      if (col_axis) begin
        for (int r = 0; r < nr; r++) cells[r*COLS + line] = fill_value;
      end else begin
        for (int c = 0; c < nc; c++) cells[line*COLS + c] = fill_value;
      end
    end
  endtask

  task automatic apply_request(output cell_result_t res);
    int nr, nc, ri, ci, pr, pc, dr, dc;
    nr = used_size(rows_reg, ROWS);
    nc = used_size(cols_reg, COLS);
    ri = int'(req.row_index);
    ci = int'(req.col_index);
    dr = int'(req.row_shift);
    dc = int'(req.col_shift);
    res.value  = '0;
    res.status = 1'b0;
    case (req.op)
      OP_READ, OP_WRITE: begin
        if (ri >= nr || ci >= nc) begin
          res.status = 1'b1;
          if (req.op == OP_READ) res.value = fill_value;
        end else begin
          pr = (ri + row_org % nr) % nr;
          pc = (ci + col_org % nc) % nc;
          if (req.op == OP_READ) res.value = cells[pr*COLS + pc];
          else cells[pr*COLS + pc] = req.write_value;
        end
      end
      OP_SHIFT: begin
        if (dr != 0) scroll_axis(1'b0, dr, nr, nc);
        if (dc != 0) scroll_axis(1'b1, dc, nr, nc);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    cell_result_t want;
    if (rst) begin
      for (int i = 0; i < ROWS*COLS; i++) cells[i] = '0;
      row_org    = 0;
      col_org    = 0;
      rows_reg   = SIZE_RESET;
      cols_reg   = SIZE_RESET;
      fill_value = '0;
      result_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_ROWS_USED: rows_reg = cfg.data[IDX_W-1:0];
          CFG_COLS_USED: cols_reg = cfg.data[IDX_W-1:0];
          CFG_DEFAULT:   fill_value = cfg.data[CW-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        apply_request(want);
        result_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          report("beat with nothing outstanding", rsp.read_value, '0);
        end else begin
          want = result_q.pop_front();
          if (rsp.read_value !== want.value) report("read_value", rsp.read_value, want.value);
          if (rsp.status !== want.status)
            report("status", 64'(rsp.status), 64'(want.status));
        end
        result_count++;
      end
    end
    pending <= result_q.size();
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the scrolling ring grid core: a directed opening
// on reads, writes, bounds and scrolls, then random traffic over a series of
// grid sizes and fill values, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import s2rg_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 88;

  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  s2rg_in_if  req_if ();
  s2rg_out_if rsp_if ();
  s2rg_cfg_if cfg_if ();

  int pending;
  int errors;
  int checked;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int rows_eff = 64;
  int cols_eff = 64;
  int n_read = 0, n_write = 0, n_shift = 0, n_nop = 0, n_cfg = 0;

  scrolling_2d_ring_grid_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  s2rg_grid_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .cfg     (cfg_if),
    .pending (pending),
    .errors  (errors),
    .checked (checked)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("** scrolling_2d_ring_grid_core: FAILED **");
    $finish;
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin : drain
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic int axis_size(int v);
    v = v & 127;
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic int pick_index(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(0, 127);
    if (r < 5) return $urandom_range(0, ((n < 4) ? n : 4) - 1);
    return $urandom_range(0, n - 1);
  endfunction

  // big grids get short scrolls only, since a full refill there rewrites the whole grid
  function automatic int pick_delta(int n);
    int r, mag;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (n > 16) mag = $urandom_range(1, 3);
    else if (r < 7) mag = (n > 1) ? $urandom_range(1, n - 1) : 1;
    else if (r < 9) mag = $urandom_range(n, 64);
    else return int'($urandom_range(0, 255)) - 128;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_item(input op_t op, input int ri, input int ci, input logic [63:0] wv,
                           input int dr, input int dc, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.row_index   <= IDX_W'(ri);
    req_if.col_index   <= IDX_W'(ci);
    req_if.write_value <= wv;
    req_if.row_shift   <= SHIFT_W'(dr);
    req_if.col_shift   <= SHIFT_W'(dc);
    do @(posedge clk); while (!req_if.ready);
    case (op)
      OP_READ:  n_read++;
      OP_WRITE: n_write++;
      OP_SHIFT: n_shift++;
      default:  n_nop++;
    endcase
  endtask

  task automatic random_item(input bit may_idle);
    int pick;
    op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_READ;
    else if (pick < 75) op = OP_WRITE;
    else if (pick < 94) op = OP_SHIFT;
    else op = OP_NOP;
    send_item(op, pick_index(rows_eff), pick_index(cols_eff), {$urandom, $urandom},
              pick_delta(rows_eff), pick_delta(cols_eff), may_idle);
  endtask

  // drop valid and wait until every outstanding result has been taken
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_config(input int rows_val, input int cols_val, input logic [63:0] dflt);
    cfg_reg_t    idx [3];
    logic [63:0] val [3];
    idx    = '{CFG_ROWS_USED, CFG_COLS_USED, CFG_DEFAULT};
    val[0] = {$urandom, $urandom};
    val[0][IDX_W-1:0] = IDX_W'(rows_val);
    val[1] = {$urandom, $urandom};
    val[1][IDX_W-1:0] = IDX_W'(cols_val);
    val[2] = dflt;
    for (int k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk); while (!cfg_if.ready);
      n_cfg++;
    end
    cfg_if.valid <= 1'b0;
    rows_eff = axis_size(rows_val);
    cols_eff = axis_size(cols_val);
  endtask

  initial begin : stimulus
    int rows_list [PHASES] = '{0, 64, 5, 2, 100, 13, 1, 0, 6};
    int cols_list [PHASES] = '{127, 64, 7, 3, 1, 9, 1, 0, 4};
    int rows_val, cols_val;
    logic [63:0] dflt;
    bit may_idle;

    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_NOP;
    req_if.row_index   <= '0;
    req_if.col_index   <= '0;
    req_if.write_value <= '0;
    req_if.row_shift   <= '0;
    req_if.col_shift   <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_ROWS_USED;
    cfg_if.data        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset sizes, fill value zero: cleared store, corners, bounds, scrolls
    send_item(OP_READ, 0, 0, {$urandom, $urandom}, 0, 0, 1'b1);
    send_item(OP_WRITE, 63, 63, '1, 0, 0, 1'b1);
    send_item(OP_READ, 63, 63, '0, 0, 0, 1'b1);
    send_item(OP_WRITE, 0, 0, 64'h0123_4567_89ab_cdef, 0, 0, 1'b1);
    send_item(OP_READ, 64, 0, {$urandom, $urandom}, 0, 0, 1'b1);
    send_item(OP_READ, 0, 127, {$urandom, $urandom}, 0, 0, 1'b1);
    send_item(OP_WRITE, 127, 5, {$urandom, $urandom}, 0, 0, 1'b1);
    send_item(OP_NOP, 5, 9, {$urandom, $urandom}, -3, 7, 1'b1);
    send_item(OP_SHIFT, 0, 0, {$urandom, $urandom}, 1, 0, 1'b1);
    send_item(OP_READ, 62, 63, '0, 0, 0, 1'b1);
    send_item(OP_SHIFT, 0, 0, {$urandom, $urandom}, 0, -1, 1'b1);
    send_item(OP_READ, 62, 0, '0, 0, 0, 1'b1);
    send_item(OP_SHIFT, 0, 0, '0, -64, 64, 1'b1);
    send_item(OP_READ, 0, 0, '0, 0, 0, 1'b1);

    // small grid with a visible fill value: extreme deltas and partial scrolls
    drain_results();
    set_config(5, 7, 64'ha5a5_5a5a_f00d_0001);
    send_item(OP_WRITE, 4, 6, 64'h8000_0000_0000_0001, 0, 0, 1'b1);
    send_item(OP_WRITE, 0, 0, 64'hfeed_beef_cafe_f00d, 0, 0, 1'b1);
    send_item(OP_SHIFT, 0, 0, '0, 127, -128, 1'b1);
    send_item(OP_READ, 4, 6, '0, 0, 0, 1'b1);
    send_item(OP_WRITE, 2, 3, 64'h7fff_ffff_ffff_fffe, 0, 0, 1'b1);
    send_item(OP_SHIFT, 0, 0, '0, 2, 0, 1'b1);
    send_item(OP_READ, 0, 3, '0, 0, 0, 1'b1);
    send_item(OP_SHIFT, 0, 0, '0, -3, 5, 1'b1);
    send_item(OP_SHIFT, 0, 0, '0, 0, 0, 1'b1);
    send_item(OP_READ, 3, 1, '0, 0, 0, 1'b1);
    send_item(OP_READ, 5, 7, '0, 0, 0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      calm     = (p == PHASES - 1);
      rows_val = (p == 7) ? $urandom_range(0, 127) : rows_list[p];
      cols_val = (p == 7) ? $urandom_range(0, 127) : cols_list[p];
      case (p % 3)
        0:       dflt = '1;
        1:       dflt = {$urandom, $urandom};
        default: dflt = '0;
      endcase
      set_config(rows_val, cols_val, dflt);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long response hold-off while requests keep coming back to back
        if (p == 2 && i == 10) hold_req = 1'b1;
        may_idle = !(p == 2 && i >= 10 && i < 40);
        if (p == 4 && i == 40) drain_results();
        random_item(may_idle);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d requests: %0d reads, %0d writes, %0d scrolls, %0d no-ops",
             n_read + n_write + n_shift + n_nop, n_read, n_write, n_shift, n_nop);
    $display("%0d register writes over %0d grid settings, %0d results checked, %0d errors",
             n_cfg, PHASES + 1, checked, errors);
    if (errors == 0) begin
      $display("** scrolling_2d_ring_grid_core: PASSED **");
    end else begin
      $display("** scrolling_2d_ring_grid_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/s2rg_pkg.sv
sv/s2rg_if.sv
sv/s2rg_ram.sv
sv/s2rg_rem.sv
sv/s2rg_dp.sv
sv/s2rg_ctrl.sv
sv/scrolling_2d_ring_grid_core.sv
dv/s2rg_grid_checker.sv
dv/tb.sv
